// ===== src/psm_pkg.sv =====
// Package for the planar shadow matrix block: payload structs, register
// codes, widths and reset values. No dependencies.
`default_nettype none

package psm_pkg;

  localparam int CoordWidth = 24;
  localparam int ValueWidth = 48;
  localparam int QueueDepth = 4;
  localparam int AddrWidth  = 4;
  localparam int DataWidth  = 32;
  localparam int CrossWidth = 2 * CoordWidth + 3;

  // register indexes on the configuration port
  localparam logic [1:0] RegLightX = 2'd0;
  localparam logic [1:0] RegLightY = 2'd1;
  localparam logic [1:0] RegLightZ = 2'd2;
  localparam logic [1:0] RegLightW = 2'd3;

  localparam logic [CoordWidth-1:0] LightXyzReset = CoordWidth'(256);
  localparam logic [CoordWidth-1:0] LightWReset   = '0;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [CrossWidth-1:0] cross_t;
  typedef logic [3:0][CoordWidth-1:0]   light_t;

  typedef struct packed {
    coord_t point0_x;
    coord_t point0_y;
    coord_t point0_z;
    coord_t point1_x;
    coord_t point1_y;
    coord_t point1_z;
    coord_t point2_x;
    coord_t point2_y;
    coord_t point2_z;
  } psm_in_t;

  typedef struct packed {
    logic [1:0]                   row_index;
    logic signed [ValueWidth-1:0] col0_value;
    logic signed [ValueWidth-1:0] col1_value;
    logic signed [ValueWidth-1:0] col2_value;
    logic signed [ValueWidth-1:0] col3_value;
    logic                         degenerate;
    logic                         last_row;
  } psm_out_t;

  // one request (cross product and point 2) waiting for the back engine
  typedef struct packed {
    cross_t cross_x;
    cross_t cross_y;
    cross_t cross_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
  } psm_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } psm_qstat_t;

endpackage

`default_nettype wire

// ===== src/planar_shadow_matrix.sv =====
// Top level of the planar shadow matrix block: light registers on an APB-style
// port, front end, request queue and back engine. Uses psm_pkg and psm_*.
//
// Usage: drive three plane points on in_i and raise start; the request is
// taken at a clock edge where start is high and busy is low. busy rises only
// when QUEUE_DEPTH requests are in flight, so several can be handed over back
// to back. Each request yields four rows on result_o, rows 0 to 3 in order,
// each valid for exactly one cycle while result_valid_o is high; the receiver
// must take them as they come.
// Sequence: the cross product in the front pipeline, then the back engine:
// load, normalize shifts plus a check, squaring, square root steps, a divide
// per component and the terms on the shared multiplier, rows spaced apart.
// The back engine pops a new request only when through with the last, as it
// has a single square root, divider and multiplier; a degenerate plane skips
// square root and divide. Light registers (x, y, z, w at byte addresses 0,
// 4, 8, 12) must be written by the user only while the block is idle; the
// block itself does not enforce this. Reset sets the light to (1.0, 1.0,
// 1.0, 0) and empties the queue; no result is pending after reset.
`default_nettype none

module planar_shadow_matrix #(
  parameter int QUEUE_DEPTH = psm_pkg::QueueDepth
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start,
  output logic                             busy,
  input  psm_pkg::psm_in_t                 in_i,
  output logic                             result_valid_o,
  output psm_pkg::psm_out_t                result_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [psm_pkg::AddrWidth-1:0]     paddr,
  input  wire [psm_pkg::DataWidth-1:0]     pwdata,
  output logic [psm_pkg::DataWidth-1:0]    prdata,
  output logic                             pready
);
  import psm_pkg::*;

  light_t     light_q;
  logic       push, pop;
  psm_entry_t push_entry, pop_entry;
  psm_qstat_t qstat;
  logic       cfg_wr;

  // light registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q[RegLightX] <= LightXyzReset;
      light_q[RegLightY] <= LightXyzReset;
      light_q[RegLightZ] <= LightXyzReset;
      light_q[RegLightW] <= LightWReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegLightX: light_q[RegLightX] <= pwdata[CoordWidth-1:0];
        RegLightY: light_q[RegLightY] <= pwdata[CoordWidth-1:0];
        RegLightZ: light_q[RegLightZ] <= pwdata[CoordWidth-1:0];
        default:   light_q[RegLightW] <= pwdata[CoordWidth-1:0];
      endcase
    end
  end

  assign prdata = DataWidth'(light_q[paddr[3:2]]);

  psm_front #(.Depth(QUEUE_DEPTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .in_i    (in_i),
    .pop_i   (pop),
    .push_o  (push),
    .entry_o (push_entry)
  );

  psm_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .stat_o  (qstat)
  );

  psm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (qstat),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .light_i     (light_q),
    .out_valid_o (result_valid_o),
    .out_o       (result_o)
  );

  // the credit count keeps the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!qstat.full || pop))
    else $error("queue pushed while full");

  // rows of one request are spaced apart
  a_row_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_row |=> !result_valid_o)
    else $error("rows emitted in consecutive cycles");

  // a degenerate plane yields an all-zero matrix
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.degenerate |->
      (result_o.col0_value == '0) && (result_o.col1_value == '0) &&
      (result_o.col2_value == '0) && (result_o.col3_value == '0))
    else $error("degenerate plane with nonzero entry");

endmodule

`default_nettype wire

// ===== src/psm_front.sv =====
// Front end: accepts requests, forms edge vectors and the cross product in a
// three-stage pipeline, and pushes the result into the queue. Uses psm_pkg.
`default_nettype none

module psm_front #(
  parameter int Depth = psm_pkg::QueueDepth
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  output logic                 busy_o,
  input  psm_pkg::psm_in_t     in_i,
  input  wire                  pop_i,
  output logic                 push_o,
  output psm_pkg::psm_entry_t  entry_o
);
  import psm_pkg::*;

  localparam int DW    = CoordWidth + 1;
  localparam int PW    = 2 * DW;
  localparam int CNT_W = $clog2(Depth + 1);

  logic                 accept;
  logic [CNT_W-1:0]     cnt_q;
  logic                 s1_v_q, s2_v_q, s3_v_q;
  logic signed [DW-1:0] v1_q [3];
  logic signed [DW-1:0] v2_q [3];
  coord_t               p2_s1_q [3];
  coord_t               p2_s2_q [3];
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];
  psm_entry_t           entry_q;

  // hold a credit for every request between accept and pop
  assign accept = start_i & ~busy_o;
  assign busy_o = (cnt_q == CNT_W'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (accept && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!accept && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // stage 1: edge vectors
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v1_q[0] <= DW'(in_i.point0_x) - DW'(in_i.point1_x);
      v1_q[1] <= DW'(in_i.point0_y) - DW'(in_i.point1_y);
      v1_q[2] <= DW'(in_i.point0_z) - DW'(in_i.point1_z);
      v2_q[0] <= DW'(in_i.point1_x) - DW'(in_i.point2_x);
      v2_q[1] <= DW'(in_i.point1_y) - DW'(in_i.point2_y);
      v2_q[2] <= DW'(in_i.point1_z) - DW'(in_i.point2_z);
      p2_s1_q[0] <= in_i.point2_x;
      p2_s1_q[1] <= in_i.point2_y;
      p2_s1_q[2] <= in_i.point2_z;
    end
  end

  // stage 2: six partial products
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      pa_q[0] <= v1_q[1] * v2_q[2];
      pb_q[0] <= v1_q[2] * v2_q[1];
      pa_q[1] <= v1_q[2] * v2_q[0];
      pb_q[1] <= v1_q[0] * v2_q[2];
      pa_q[2] <= v1_q[0] * v2_q[1];
      pb_q[2] <= v1_q[1] * v2_q[0];
      p2_s2_q <= p2_s1_q;
    end
  end

  // stage 3: cross product components
  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      entry_q.cross_x <= CrossWidth'(pa_q[0]) - CrossWidth'(pb_q[0]);
      entry_q.cross_y <= CrossWidth'(pa_q[1]) - CrossWidth'(pb_q[1]);
      entry_q.cross_z <= CrossWidth'(pa_q[2]) - CrossWidth'(pb_q[2]);
      entry_q.p2_x    <= p2_s2_q[0];
      entry_q.p2_y    <= p2_s2_q[1];
      entry_q.p2_z    <= p2_s2_q[2];
    end
  end

  assign push_o  = s3_v_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== src/psm_queue.sv =====
// Request queue between front end and back engine. Uses psm_pkg.
`default_nettype none

module psm_queue #(
  parameter int Depth = psm_pkg::QueueDepth
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  psm_pkg::psm_entry_t  entry_i,
  input  wire                  pop_i,
  output psm_pkg::psm_entry_t  entry_o,
  output psm_pkg::psm_qstat_t  stat_o
);
  import psm_pkg::*;

  localparam int PTR_W = $clog2(Depth);
  localparam int CNT_W = $clog2(Depth + 1);

  psm_entry_t       mem_q [Depth];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  // store the entry at the write pointer
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign entry_o      = mem_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CNT_W'(Depth));

endmodule

`default_nettype wire

// ===== src/psm_back.sv =====
// Back engine: normalizes the cross product, takes square root and divides
// (not for a degenerate plane), then forms the plane and the matrix rows
// on one shared multiplier. Uses psm_pkg.
`default_nettype none

module psm_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  psm_pkg::psm_qstat_t  stat_i,
  input  psm_pkg::psm_entry_t  entry_i,
  output logic                 pop_o,
  input  psm_pkg::light_t      light_i,
  output logic                 out_valid_o,
  output psm_pkg::psm_out_t    out_o
);
  import psm_pkg::*;

  localparam int W     = CoordWidth;
  localparam int CW    = CrossWidth;
  localparam int PL_W  = W + 20;
  localparam int HI_W  = PL_W - 24;
  localparam int MA    = (HI_W > 25) ? HI_W : 25;
  localparam int MP    = MA + W;
  localparam int ACC_W = (2 * W + 24 > 66) ? 2 * W + 24 : 66;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIVI = 3'd4;
  localparam logic [2:0] S_DIVR = 3'd5;
  localparam logic [2:0] S_MAC  = 3'd6;

  localparam logic [1:0] OpD   = 2'd0;
  localparam logic [1:0] OpDot = 2'd1;
  localparam logic [1:0] OpEnt = 2'd2;

  localparam logic signed [ACC_W-1:0] SatMax =
    {{(ACC_W - ValueWidth + 1){1'b0}}, {(ValueWidth - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SatMin =
    {{(ACC_W - ValueWidth + 1){1'b1}}, {(ValueWidth - 1){1'b0}}};

  function automatic logic signed [ValueWidth-1:0] round_sat(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] r;
    r = (v + ACC_W'(32768)) >>> 16;
    if (r > SatMax) begin
      return SatMax[ValueWidth-1:0];
    end else if (r < SatMin) begin
      return SatMin[ValueWidth-1:0];
    end
    return r[ValueWidth-1:0];
  endfunction

  logic [2:0]              state_q;
  logic [CW-1:0]           mag_q [3];
  logic                    neg_q [3];
  coord_t                  p2_q [3];
  logic                    degen_q;
  logic [4:0]              cnt_q;
  logic [59:0]             sq_q;
  logic [61:0]             sum_q;
  logic [62:0]             x_q, res_q, bit_q;
  logic [30:0]             len_q;
  logic [1:0]              k_q;
  logic [17:0]             num_q, quo_q;
  logic [31:0]             rem_q;
  logic signed [17:0]      n_q [3];
  logic signed [PL_W-1:0]  d_q;
  logic [1:0]              op_q, i_q, j_q;
  logic                    half_q, ph_q;
  logic signed [MP-1:0]    prod_q;
  logic signed [ACC_W-1:0] acc_q, dot_q;
  logic signed [ValueWidth-1:0] row_q [3];
  logic                    out_valid_q;
  psm_out_t                out_q;

  logic [CW-1:0]           orv;
  logic [29:0]             m_sel;
  logic [61:0]             sum_next;
  logic [63:0]             trial;
  logic                    sq_ge;
  logic [62:0]             x_next, res_next;
  logic [46:0]             numer;
  logic [31:0]             dtrial;
  logic                    d_ge;
  logic [17:0]             quo_next;
  logic [1:0]              pk;
  logic signed [PL_W-1:0]  pl;
  logic signed [MA-1:0]    mul_a;
  logic signed [W-1:0]     mul_b;
  logic signed [ACC_W-1:0] addend, acc_next;
  logic [1:0]              i_nx, j_nx;
  logic signed [ValueWidth-1:0] ent_val;
  logic                    cr_zero;

  assign orv = mag_q[0] | mag_q[1] | mag_q[2];

  // pick one normalized magnitude for squaring or division
  always_comb begin
    case (((state_q == S_SQ) ? cnt_q[1:0] : k_q))
      2'd0:    m_sel = mag_q[0][29:0];
      2'd1:    m_sel = mag_q[1][29:0];
      default: m_sel = mag_q[2][29:0];
    endcase
  end

  assign sum_next = (cnt_q == 5'd0) ? sum_q : sum_q + 62'(sq_q);

  // one square root step
  assign trial    = 64'(res_q) + 64'(bit_q);
  assign sq_ge    = (64'(x_q) >= trial);
  assign x_next   = sq_ge ? 63'(64'(x_q) - trial) : x_q;
  assign res_next = sq_ge ? (res_q >> 1) + bit_q : res_q >> 1;

  // one restoring division step
  assign numer    = {1'b0, m_sel, 16'b0} + 47'(len_q >> 1);
  assign dtrial   = {rem_q[30:0], num_q[17]};
  assign d_ge     = (dtrial >= {1'b0, len_q});
  assign quo_next = {quo_q[16:0], d_ge};

  // select multiplier operands for the current term
  always_comb begin
    pk = (op_q == OpEnt) ? i_q : j_q;
    case (pk)
      2'd0:    pl = PL_W'(n_q[0]) <<< 8;
      2'd1:    pl = PL_W'(n_q[1]) <<< 8;
      2'd2:    pl = PL_W'(n_q[2]) <<< 8;
      default: pl = d_q;
    endcase
    if (op_q == OpD) begin
      case (j_q)
        2'd0: begin
          mul_a = MA'(n_q[0]);
          mul_b = p2_q[0];
        end
        2'd1: begin
          mul_a = MA'(n_q[1]);
          mul_b = p2_q[1];
        end
        default: begin
          mul_a = MA'(n_q[2]);
          mul_b = p2_q[2];
        end
      endcase
    end else begin
      mul_a = half_q ? MA'($signed(pl[PL_W-1:24])) : MA'($signed({1'b0, pl[23:0]}));
      mul_b = $signed(light_i[j_q]);
    end
  end

  assign addend   = half_q ? (ACC_W'(prod_q) <<< 24) : ACC_W'(prod_q);
  assign acc_next = (op_q == OpEnt) ? acc_q - addend : acc_q + addend;
  assign ent_val  = round_sat(acc_next);
  assign j_nx     = j_q + 2'd1;
  assign i_nx     = (j_q == 2'd3) ? i_q + 2'd1 : i_q;
  assign cr_zero  = (entry_i.cross_x == '0) && (entry_i.cross_y == '0) &&
                    (entry_i.cross_z == '0);

  assign pop_o = (state_q == S_IDLE) && !stat_i.empty;

  // sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
      op_q        <= OpD;
      i_q         <= '0;
      j_q         <= '0;
      half_q      <= 1'b0;
      ph_q        <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!stat_i.empty) begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (orv == '0) begin
            state_q <= S_MAC;
            op_q    <= OpD;
            i_q     <= '0;
            j_q     <= '0;
            half_q  <= 1'b0;
            ph_q    <= 1'b0;
          end else if (orv[CW-1:30] == '0 && orv[29]) begin
            state_q <= S_SQ;
            cnt_q   <= '0;
          end
        end
        S_SQ: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd3) begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (bit_q[0]) begin
            state_q <= S_DIVI;
            k_q     <= '0;
          end
        end
        S_DIVI: begin
          state_q <= S_DIVR;
          cnt_q   <= '0;
        end
        S_DIVR: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd17) begin
            if (k_q == 2'd2) begin
              state_q <= S_MAC;
              op_q    <= OpD;
              i_q     <= '0;
              j_q     <= '0;
              half_q  <= 1'b0;
              ph_q    <= 1'b0;
            end else begin
              state_q <= S_DIVI;
              k_q     <= k_q + 2'd1;
            end
          end
        end
        S_MAC: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            unique case (op_q)
              OpD: begin
                if (j_q == 2'd2) begin
                  op_q <= OpDot;
                  j_q  <= '0;
                end else begin
                  j_q <= j_nx;
                end
              end
              OpDot: begin
                half_q <= ~half_q;
                if (half_q) begin
                  j_q <= j_nx;
                  if (j_q == 2'd3) begin
                    op_q <= OpEnt;
                    i_q  <= '0;
                  end
                end
              end
              default: begin
                half_q <= ~half_q;
                if (half_q) begin
                  j_q <= j_nx;
                  i_q <= i_nx;
                  if (j_q == 2'd3) begin
                    out_valid_q <= 1'b1;
                    if (i_q == 2'd3) begin
                      state_q <= S_IDLE;
                    end
                  end
                end
              end
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (!stat_i.empty) begin
          neg_q[0] <= entry_i.cross_x[CW-1];
          neg_q[1] <= entry_i.cross_y[CW-1];
          neg_q[2] <= entry_i.cross_z[CW-1];
          mag_q[0] <= entry_i.cross_x[CW-1] ? CW'(-entry_i.cross_x) : entry_i.cross_x;
          mag_q[1] <= entry_i.cross_y[CW-1] ? CW'(-entry_i.cross_y) : entry_i.cross_y;
          mag_q[2] <= entry_i.cross_z[CW-1] ? CW'(-entry_i.cross_z) : entry_i.cross_z;
          p2_q[0]  <= entry_i.p2_x;
          p2_q[1]  <= entry_i.p2_y;
          p2_q[2]  <= entry_i.p2_z;
          degen_q  <= cr_zero;
        end
      end
      S_NORM: begin
        // shift all three so the largest lands in [2^29, 2^30)
        if (orv == '0) begin
          n_q[0] <= '0;
          n_q[1] <= '0;
          n_q[2] <= '0;
          acc_q  <= '0;
        end else if (orv[CW-1:30] != '0) begin
          mag_q[0] <= mag_q[0] >> 1;
          mag_q[1] <= mag_q[1] >> 1;
          mag_q[2] <= mag_q[2] >> 1;
        end else if (!orv[29]) begin
          mag_q[0] <= mag_q[0] << 1;
          mag_q[1] <= mag_q[1] << 1;
          mag_q[2] <= mag_q[2] << 1;
        end
        sum_q <= '0;
      end
      S_SQ: begin
        sq_q  <= 60'(m_sel) * 60'(m_sel);
        sum_q <= sum_next;
        if (cnt_q == 5'd3) begin
          x_q   <= 63'(sum_next);
          res_q <= '0;
          bit_q <= {1'b1, 62'b0};
        end
      end
      S_SQRT: begin
        x_q   <= x_next;
        res_q <= res_next;
        bit_q <= bit_q >> 2;
        len_q <= res_next[30:0];
      end
      S_DIVI: begin
        rem_q <= {3'b0, numer[46:18]};
        num_q <= numer[17:0];
        quo_q <= '0;
      end
      S_DIVR: begin
        rem_q <= d_ge ? dtrial - {1'b0, len_q} : dtrial;
        num_q <= num_q << 1;
        quo_q <= quo_next;
        if (cnt_q == 5'd17) begin
          case (k_q)
            2'd0:    n_q[0] <= neg_q[0] ? -$signed(quo_next) : $signed(quo_next);
            2'd1:    n_q[1] <= neg_q[1] ? -$signed(quo_next) : $signed(quo_next);
            default: n_q[2] <= neg_q[2] ? -$signed(quo_next) : $signed(quo_next);
          endcase
          acc_q <= '0;
        end
      end
      S_MAC: begin
        if (!ph_q) begin
          prod_q <= mul_a * mul_b;
        end else begin
          case (op_q)
            OpD: begin
              if (j_q == 2'd2) begin
                d_q   <= PL_W'(-acc_next);
                acc_q <= '0;
              end else begin
                acc_q <= acc_next;
              end
            end
            OpDot: begin
              acc_q <= acc_next;
              dot_q <= acc_next;
            end
            default: begin
              if (!half_q) begin
                acc_q <= acc_next;
              end else begin
                // store entry, seed next with the dot on the diagonal
                acc_q <= (i_nx == j_nx) ? dot_q : '0;
                case (j_q)
                  2'd0: row_q[0] <= ent_val;
                  2'd1: row_q[1] <= ent_val;
                  2'd2: row_q[2] <= ent_val;
                  default: begin
                    out_q.row_index  <= i_q;
                    out_q.col0_value <= row_q[0];
                    out_q.col1_value <= row_q[1];
                    out_q.col2_value <= row_q[2];
                    out_q.col3_value <= ent_val;
                    out_q.degenerate <= degen_q;
                    out_q.last_row   <= (i_q == 2'd3);
                  end
                endcase
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire
